### src/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// shared types and constants of the dirty rectangle tracker
// ----------------------------------------------------------------------------
package drt_pkg;

    // default geometry and list size
    localparam int MAX_RECTS_DEF = 32;
    localparam int SCREEN_W_DEF  = 240;
    localparam int SCREEN_H_DEF  = 240;

    // rectangle store geometry
    localparam int STORE_DEPTH = 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // command queue depth
    localparam int Q_DEPTH = 4;

    // input opcodes
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // one input beat
    typedef struct packed {
        logic        opcode;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] span_x;
        logic [15:0] span_y;
    } t_in;

    // one result beat
    typedef struct packed {
        logic [7:0] erase_left;
        logic [7:0] erase_top;
        logic [7:0] erase_width;
        logic [7:0] erase_height;
        logic       full_screen;
        logic [7:0] fill_colour;
        logic       last_rect;
    } t_out;

    // a clipped rectangle as kept in the store
    typedef struct packed {
        logic [7:0] height;
        logic [7:0] width;
        logic [7:0] top;
        logic [7:0] left;
    } t_rect;

    // classified command handed from front to back
    typedef struct packed {
        logic  is_flush;
        t_rect rect;
    } t_cmd;

endpackage

### src/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front
// accepts input beats, drops unusable marks, clips marks to the screen
// ----------------------------------------------------------------------------
module drt_front import drt_pkg::*; #(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_q_full
);

    localparam logic [16:0] W17 = 17'(SCREEN_W);
    localparam logic [16:0] H17 = 17'(SCREEN_H);

    logic        r_valid;
    logic        n_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        accept;
    logic        keep;
    logic        on_screen;
    logic [16:0] x17;
    logic [16:0] y17;
    logic [16:0] x_end;
    logic [16:0] y_end;
    logic [16:0] w_rem;
    logic [16:0] h_rem;

    // handshake
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;

    // classify and clip
    always_comb begin
        x17       = {1'b0, i_in_data.left};
        y17       = {1'b0, i_in_data.top};
        x_end     = x17 + {1'b0, i_in_data.span_x};
        y_end     = y17 + {1'b0, i_in_data.span_y};
        w_rem     = W17 - x17;
        h_rem     = H17 - y17;
        on_screen = (x17 < W17) && (y17 < H17) &&
                    (i_in_data.span_x != 16'd0) && (i_in_data.span_y != 16'd0);
        keep      = (i_in_data.opcode == OP_FLUSH) || on_screen;

        n_cmd.is_flush  = (i_in_data.opcode == OP_FLUSH);
        n_cmd.rect.left = i_in_data.left[7:0];
        n_cmd.rect.top  = i_in_data.top[7:0];
        n_cmd.rect.width  = (x_end > W17) ? w_rem[7:0] : i_in_data.span_x[7:0];
        n_cmd.rect.height = (y_end > H17) ? h_rem[7:0] : i_in_data.span_y[7:0];
    end

    // holding register valid
    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept && keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // command payload
    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### src/drt_queue.sv
// ----------------------------------------------------------------------------
// drt_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module drt_queue import drt_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_cmd              r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/drt_back.sv
// ----------------------------------------------------------------------------
// drt_back
// rectangle store, overflow tracking, flush sequencer and output register
// ----------------------------------------------------------------------------
module drt_back import drt_pkg::*; #(
    parameter int MAX_RECTS = MAX_RECTS_DEF,
    parameter int SCREEN_W  = SCREEN_W_DEF,
    parameter int SCREEN_H  = SCREEN_H_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_q_empty,
    output logic       o_pop,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data
);

    localparam int LIST_CAP = (MAX_RECTS < STORE_DEPTH) ? MAX_RECTS : STORE_DEPTH;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LIST_CAP);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    t_rect             r_mem [STORE_DEPTH];
    logic              r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [IDX_W-1:0]  r_idx;
    logic [7:0]        r_colour;
    t_rect             r_rd_data;
    logic              r_rd_valid;
    logic              r_rd_full;
    logic              r_rd_last;
    logic              r_ov;
    t_out              r_out;
    t_out              n_out;
    logic              out_load;
    logic              slot_free;
    logic              rd_en;
    logic              rd_last;
    logic              wr_en;
    logic              pop_mark;
    logic              pop_flush;
    logic              ovf_flush;

    // handshake helpers
    assign out_load  = r_rd_valid && (!r_ov || !i_out_stall);
    assign slot_free = !r_rd_valid || out_load;
    assign o_pop     = !i_q_empty && (r_state == ST_IDLE) &&
                       (!i_cmd.is_flush || slot_free);
    assign pop_mark  = o_pop && !i_cmd.is_flush;
    assign pop_flush = o_pop && i_cmd.is_flush;
    assign ovf_flush = pop_flush && r_ovf;
    assign wr_en     = pop_mark && !r_ovf && (r_count < CAP);
    assign rd_en     = (r_state == ST_FLUSH) && slot_free;
    assign rd_last   = ({1'b0, r_idx} + CNT_W'(1)) == r_count;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= '0;
        end else if (i_cfg_valid) begin
            r_colour <= i_cfg_data;
        end
    end

    // rectangle store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_cmd.rect;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // list control and flush sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (pop_mark && !r_ovf) begin
                        if (r_count < CAP) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    if (pop_flush) begin
                        r_idx <= '0;
                        if (r_ovf) begin
                            r_ovf   <= 1'b0;
                            r_count <= '0;
                        end else if (r_count != '0) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (rd_en) begin
                        r_idx <= r_idx + 1'b1;
                        if (rd_last) begin
                            r_state <= ST_IDLE;
                            r_count <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // read slot between store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_full  <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_valid <= 1'b1;
                r_rd_full  <= 1'b0;
                r_rd_last  <= rd_last;
            end else if (ovf_flush) begin
                r_rd_valid <= 1'b1;
                r_rd_full  <= 1'b1;
                r_rd_last  <= 1'b1;
            end else if (out_load) begin
                r_rd_valid <= 1'b0;
            end
        end
    end

    // result beat assembly
    always_comb begin
        n_out.fill_colour = r_colour;
        n_out.last_rect   = r_rd_last;
        n_out.full_screen = r_rd_full;
        if (r_rd_full) begin
            n_out.erase_left   = 8'd0;
            n_out.erase_top    = 8'd0;
            n_out.erase_width  = 8'(SCREEN_W);
            n_out.erase_height = 8'(SCREEN_H);
        end else begin
            n_out.erase_left   = r_rd_data.left;
            n_out.erase_top    = r_rd_data.top;
            n_out.erase_width  = r_rd_data.width;
            n_out.erase_height = r_rd_data.height;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // list never grows past its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("rect count above capacity");

    // overflow only ever follows a full list
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CAP))
        else $error("overflow set with list not full");

    // a flush walk always has entries to read
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_count != '0) && !r_ovf)
        else $error("flush walk on empty or overflowed list");

    // a full-screen erase is always the only beat of its flush
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && r_rd_full) |-> r_rd_last)
        else $error("full-screen erase not flagged last");

    // the store is never written while a flush walk runs
    a_no_wr_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !wr_en)
        else $error("store write during flush");

endmodule

### src/dirty_rect_tracker.sv
// ----------------------------------------------------------------------------
// dirty_rect_tracker
// records rectangles drawn during a frame and replays them as erase work
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): a mark beat clips its
// rectangle to the screen and appends it; off-screen or empty marks and marks
// after overflow are dropped. A flush beat replays the list and empties it.
// Output channel (o_out_valid / i_out_stall / o_out_data): one beat per stored
// rectangle in mark order with last_rect on the final one, or a single
// full-screen beat after overflow, or nothing for an empty list.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): erase colour,
// always ready; write it only while the block is idle.
// Throughput: one input beat per cycle while the queue has room. The back end
// takes a flush as one command, then reads the store once per rectangle, and
// pops no command until that walk ends; results one per cycle while the
// receiver does not stall. A flush reaches its first listed result through the
// front register, command queue, flush state, store read and output register;
// the full-screen erase skips the flush state and the store read.
// Reset: list empty, overflow clear, colour 0; no clearing pass is needed.
// A stalled receiver holds the output register; the flush walk pauses and the
// command queue then fills until o_in_stall rises.
// ----------------------------------------------------------------------------
module dirty_rect_tracker import drt_pkg::*; #(
    parameter int MAX_RECTS = MAX_RECTS_DEF,
    parameter int SCREEN_W  = SCREEN_W_DEF,
    parameter int SCREEN_H  = SCREEN_H_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic pop;
    t_cmd pop_cmd;
    logic q_empty;

    // accept and classify
    drt_front #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_full   (q_full)
    );

    // command queue
    drt_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (q_empty)
    );

    // store and replay
    drt_back #(
        .MAX_RECTS (MAX_RECTS),
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pop_cmd),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### sim/drt_erase_checker.sv
// ----------------------------------------------------------------------------
// drt_erase_checker
// predicts the erase beats of the dirty rectangle tracker and checks them
// ----------------------------------------------------------------------------
// Watches the input, output and colour channels. Every accepted input beat
// updates a private copy of the rectangle list. A flush beat queues the erase
// beats it must cause. Every accepted output beat is compared with the oldest
// queued beat. The failure count and the number of beats still due go to the
// top level.
// ----------------------------------------------------------------------------
module drt_erase_checker import drt_pkg::*; #(
    parameter int MAX_RECTS = MAX_RECTS_DEF,
    parameter int SCREEN_W  = SCREEN_W_DEF,
    parameter int SCREEN_H  = SCREEN_H_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in        i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out       i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_erase_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = (MAX_RECTS < STORE_DEPTH) ? MAX_RECTS : STORE_DEPTH;
    localparam int REPORT_LIMIT = 10;

    // private copy of the tracker state
    t_rect       marked [STORE_DEPTH];
    int          marked_count;
    logic        overflow_hit;
    logic [7:0]  fill_value;

    // erase beats owed by accepted flushes, oldest first
    t_out        erase_due [$];
    int          fail_total;

    initial begin
        o_fail_count = 0;
        o_erase_due  = 0;
        marked_count = 0;
        overflow_hit = 1'b0;
        fill_value   = '0;
        fail_total   = 0;
    end

    function automatic string erase_text(input t_out b);
        return $sformatf("left=%0d top=%0d width=%0d height=%0d full=%0b colour=%0d last=%0b",
                         b.erase_left, b.erase_top, b.erase_width, b.erase_height,
                         b.full_screen, b.fill_colour, b.last_rect);
    endfunction

    // apply one input beat: marks grow the list, a flush owes erase beats
    task automatic track_beat(input t_in beat);
        int   x;
        int   y;
        int   w;
        int   h;
        int   i;
        t_out e;
        x = beat.left;
        y = beat.top;
        w = beat.span_x;
        h = beat.span_y;
        if (beat.opcode == OP_MARK) begin
            // dropped after overflow, off screen, or empty
            if (!overflow_hit && x < SCREEN_W && y < SCREEN_H && w != 0 && h != 0) begin
                if (x + w > SCREEN_W) w = SCREEN_W - x;
                if (y + h > SCREEN_H) h = SCREEN_H - y;
                if (marked_count >= LIST_CAP) begin
                    overflow_hit = 1'b1;
                end else begin
                    marked[marked_count % STORE_DEPTH].left   = x[7:0];
                    marked[marked_count % STORE_DEPTH].top    = y[7:0];
                    marked[marked_count % STORE_DEPTH].width  = w[7:0];
                    marked[marked_count % STORE_DEPTH].height = h[7:0];
                    marked_count++;
                end
            end
        end else begin
            if (overflow_hit) begin
                // one whole-screen erase replaces the list
                e.erase_left   = '0;
                e.erase_top    = '0;
                e.erase_width  = 8'(SCREEN_W);
                e.erase_height = 8'(SCREEN_H);
                e.full_screen  = 1'b1;
                e.fill_colour  = fill_value;
                e.last_rect    = 1'b1;
                erase_due.push_back(e);
            end else begin
                for (i = 0; i < marked_count && i < STORE_DEPTH; i++) begin
                    e.erase_left   = marked[i].left;
                    e.erase_top    = marked[i].top;
                    e.erase_width  = marked[i].width;
                    e.erase_height = marked[i].height;
                    e.full_screen  = 1'b0;
                    e.fill_colour  = fill_value;
                    e.last_rect    = (i + 1 == marked_count);
                    erase_due.push_back(e);
                end
            end
            marked_count = 0;
            overflow_hit = 1'b0;
        end
    endtask

    // compare one output beat with the oldest one owed
    task automatic check_erase(input t_out got);
        t_out want;
        if (erase_due.size() == 0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("[%0t] erase beat with none expected: %s", $time, erase_text(got));
        end else begin
            want = erase_due.pop_front();
            if (got !== want) begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT) begin
                    $display("[%0t] erase beat mismatch", $time);
                    $display("    expected %s", erase_text(want));
                    $display("    actual   %s", erase_text(got));
                end
            end
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marked_count = 0;
            overflow_hit = 1'b0;
            fill_value   = '0;
            erase_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) fill_value = i_cfg_data;
            if (i_in_valid && !i_in_stall) track_beat(i_in_data);
            if (i_out_valid && !i_out_stall) check_erase(i_out_data);
        end
        o_fail_count <= fail_total;
        o_erase_due  <= erase_due.size();
    end

endmodule

### sim/dirty_rect_tracker_test.sv
// ----------------------------------------------------------------------------
// dirty_rect_tracker_test
// stimulus and verdict for the dirty rectangle tracker
// ----------------------------------------------------------------------------
// A directed frame covers screen corners, clipping, off-screen and empty marks
// and empty flushes. Random frames follow in four colour phases: short lists,
// exactly full lists, and overflowing lists followed by further marks, mixed
// with malformed marks. The sender runs in bursts with gaps, the receiver
// stalls on its own pattern. The checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module dirty_rect_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import drt_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 60;

    // frame shapes for the random part
    typedef enum int {
        FRAME_SHORT,
        FRAME_FULL,
        FRAME_OVERFLOW,
        FRAME_EMPTY
    } t_frame;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    int         fail_count;
    int         erase_due;
    int         burst_left = 0;
    int         idle_run;
    int         stall_mode = 0;
    int         stall_span = 0;

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    dirty_rect_tracker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    drt_erase_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_erase_due  (erase_due)
    );

    // receiver stall: free, sparse or heavy stretches of random length
    always @(negedge clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 80);
        end else begin
            stall_span = stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog on cycles without any accepted beat
    initial begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_in mk_beat(input logic op, input logic [15:0] l,
                                    input logic [15:0] t, input logic [15:0] w,
                                    input logic [15:0] h);
        t_in b;
        b.opcode = op;
        b.left   = l;
        b.top    = t;
        b.span_x = w;
        b.span_y = h;
        return b;
    endfunction

    function automatic logic [15:0] pick_span();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(1, 65535));
            1:       return 16'($urandom_range(1, 240));
            default: return 16'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [15:0] pick_corner();
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(200, SCREEN_W_DEF - 1));
        return 16'($urandom_range(0, SCREEN_W_DEF - 1));
    endfunction

    // on-screen mark with nonzero size, clipped when the span runs off
    function automatic t_in good_mark();
        return mk_beat(OP_MARK, pick_corner(), pick_corner(), pick_span(), pick_span());
    endfunction

    // mark the tracker must drop: off screen or empty
    function automatic t_in noise_mark();
        logic [15:0] l;
        logic [15:0] t;
        logic [15:0] w;
        logic [15:0] h;
        l = pick_corner();
        t = pick_corner();
        w = pick_span();
        h = pick_span();
        case ($urandom_range(0, 4))
            0:       l = 16'($urandom_range(SCREEN_W_DEF, 65535));
            1:       t = 16'($urandom_range(SCREEN_H_DEF, 65535));
            2:       w = '0;
            3:       h = '0;
            default: begin
                l = 16'($urandom_range(SCREEN_W_DEF, 65535));
                t = 16'($urandom);
                w = 16'($urandom);
                h = 16'($urandom);
            end
        endcase
        return mk_beat(OP_MARK, l, t, w, h);
    endfunction

    function automatic t_in flush_beat();
        return mk_beat(OP_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
    endfunction

    // one input beat, with a random gap when the current burst runs out
    task automatic send_beat(input t_in beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    // stop sending and wait until every owed erase beat has come out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (erase_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_colour(input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int LIST_CAP_DEF();
        return (MAX_RECTS_DEF < STORE_DEPTH) ? MAX_RECTS_DEF : STORE_DEPTH;
    endfunction

    // random frames: marks with some noise, then a flush
    task automatic run_frames(input t_frame first_kind, input int budget);
        int     done;
        int     marks;
        int     k;
        t_frame kind;
        done = 0;
        kind = first_kind;
        while (done < budget) begin
            case (kind)
                FRAME_FULL:     marks = LIST_CAP_DEF();
                FRAME_OVERFLOW: marks = $urandom_range(33, 38);
                FRAME_EMPTY:    marks = 0;
                default:        marks = $urandom_range(1, 6);
            endcase
            for (k = 0; k < marks; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_beat(noise_mark());
                    done++;
                end
                send_beat(good_mark());
                done++;
            end
            send_beat(flush_beat());
            done++;
            if ($urandom_range(0, 7) == 0) begin
                send_beat(flush_beat());
                done++;
            end
            case ($urandom_range(0, 11))
                0:       kind = FRAME_OVERFLOW;
                1:       kind = FRAME_FULL;
                2:       kind = FRAME_EMPTY;
                default: kind = FRAME_SHORT;
            endcase
        end
    endtask

    // main sequence
    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frame at the reset colour
        send_beat(mk_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_beat(mk_beat(OP_MARK, 16'd0, 16'd0, 16'd1, 16'd1));
        send_beat(mk_beat(OP_MARK, 16'd239, 16'd239, 16'd1, 16'd1));
        send_beat(mk_beat(OP_MARK, 16'd239, 16'd0, 16'hFFFF, 16'hFFFF));
        send_beat(mk_beat(OP_MARK, 16'd0, 16'd0, 16'd240, 16'd240));
        send_beat(mk_beat(OP_MARK, 16'd200, 16'd100, 16'd40, 16'd140));
        send_beat(mk_beat(OP_MARK, 16'd240, 16'd0, 16'd5, 16'd5));
        send_beat(mk_beat(OP_MARK, 16'd0, 16'd240, 16'd5, 16'd5));
        send_beat(mk_beat(OP_MARK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(mk_beat(OP_MARK, 16'd10, 16'd10, 16'd0, 16'd5));
        send_beat(mk_beat(OP_MARK, 16'd10, 16'd10, 16'd5, 16'd0));
        send_beat(mk_beat(OP_MARK, 16'd100, 16'd200, 16'h8000, 16'd50));
        send_beat(mk_beat(OP_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(mk_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_beat(mk_beat(OP_MARK, 16'd7, 16'd9, 16'd3, 16'd4));
        send_beat(mk_beat(OP_FLUSH, 16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0));
        settle();

        // random phases, each under its own erase colour
        write_colour(8'hFF);
        run_frames(FRAME_OVERFLOW, PHASE_ITEMS);
        settle();
        write_colour(8'h00);
        run_frames(FRAME_FULL, PHASE_ITEMS);
        settle();
        write_colour(8'($urandom));
        run_frames(FRAME_SHORT, PHASE_ITEMS);
        settle();
        write_colour(8'($urandom));
        run_frames(FRAME_OVERFLOW, PHASE_ITEMS);
        settle();

        if (fail_count == 0 && erase_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
